// ----- hdl/icr_pkg.sv -----
package icr_pkg;

    // port field widths
    localparam int ADDR_W    = 22;
    localparam int DATA_W    = 32;
    localparam int SRC_W     = 10;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    // widest source and context index the block supports
    localparam int SRC_IDX_W = 5;
    localparam int CTX_IDX_W = 4;

    // register map
    localparam logic [ADDR_W-1:0] PEND_BASE = 22'h001000;
    localparam logic [ADDR_W-1:0] ENAB_BASE = 22'h002000;
    localparam logic [ADDR_W-1:0] ENAB_END  = 22'h1F1FFC;
    localparam logic [ADDR_W-1:0] CTX_BASE  = 22'h200000;

    // offsets inside one context block
    localparam logic [11:0] CTX_OFF_THRESH = 12'h000;
    localparam logic [11:0] CTX_OFF_CLAIM  = 12'h004;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RAISE = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_BAD      = 2'd2
    } t_status;

    // decoded action handed from front to back
    typedef enum logic [3:0] {
        K_NONE,
        K_PRIO_RD,
        K_PRIO_WR,
        K_PEND_RD,
        K_ENAB_RD,
        K_ENAB_WR,
        K_THR_RD,
        K_THR_WR,
        K_CLAIM,
        K_RAISE
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [SRC_IDX_W-1:0]  src;
        logic [CTX_IDX_W-1:0]  ctx;
        logic [DATA_W-1:0]     data;
        t_status               status;
    } t_cmd;

endpackage

// ----- hdl/icr_front.sv -----
module icr_front #(
    parameter int SOURCES  = 32,
    parameter int CONTEXTS = 2
) (
    input  logic                        i_valid,
    input  logic [icr_pkg::OP_W-1:0]    i_operation,
    input  logic [icr_pkg::ADDR_W-1:0]  i_address,
    input  logic [icr_pkg::DATA_W-1:0]  i_write_data,
    input  logic [icr_pkg::SRC_W-1:0]   i_source,
    input  logic                        i_level,
    input  logic                        i_full,
    output logic                        o_stall,
    output logic                        o_push,
    output icr_pkg::t_cmd               o_cmd
);
    import icr_pkg::*;

    logic [ADDR_W-1:0] addr_w;
    logic [ADDR_W-1:0] enab_disp;
    logic              prio_hit;
    logic              pend_hit;
    logic              enab_hit;
    logic              ctx_hit;
    logic              enab_bad;
    logic [8:0]        ctx_num;
    logic [11:0]       ctx_off;
    logic              is_wr;

    // handshake: take a transfer whenever the queue has room
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // address regions, low two bits dropped
    assign addr_w    = {i_address[ADDR_W-1:2], 2'b00};
    assign prio_hit  = addr_w < ADDR_W'(SOURCES * 4);
    assign pend_hit  = addr_w == PEND_BASE;
    assign enab_hit  = (addr_w >= ENAB_BASE) && (addr_w < ENAB_END);
    assign ctx_hit   = addr_w >= CTX_BASE;
    assign enab_disp = addr_w - ENAB_BASE;
    // 128-byte enable stride: context in bits 20:7, word index in bits 6:2
    assign enab_bad  = (enab_disp[20:7] >= 14'(CONTEXTS)) || (enab_disp[6:2] != 5'd0);
    // 4 KiB context stride
    assign ctx_num   = addr_w[20:12];
    assign ctx_off   = addr_w[11:0];
    assign is_wr     = (t_op'(i_operation) == OP_WRITE);

    // classify the transfer
    always_comb begin
        o_cmd.kind   = K_NONE;
        o_cmd.src    = '0;
        o_cmd.ctx    = '0;
        o_cmd.data   = i_write_data;
        o_cmd.status = ST_OK;
        case (t_op'(i_operation))
            OP_READ, OP_WRITE: begin
                if (prio_hit) begin
                    o_cmd.kind = is_wr ? K_PRIO_WR : K_PRIO_RD;
                    o_cmd.src  = addr_w[SRC_IDX_W+1:2];
                end else if (pend_hit) begin
                    if (is_wr) begin
                        o_cmd.status = ST_UNMAPPED;
                    end else begin
                        o_cmd.kind = K_PEND_RD;
                    end
                end else if (enab_hit) begin
                    if (enab_bad) begin
                        o_cmd.status = ST_BAD;
                    end else begin
                        o_cmd.kind = is_wr ? K_ENAB_WR : K_ENAB_RD;
                        o_cmd.ctx  = enab_disp[7+CTX_IDX_W-1:7];
                    end
                end else if (ctx_hit) begin
                    o_cmd.ctx = ctx_num[CTX_IDX_W-1:0];
                    if (ctx_num >= 9'(CONTEXTS)) begin
                        o_cmd.status = ST_BAD;
                    end else if (ctx_off == CTX_OFF_THRESH) begin
                        o_cmd.kind = is_wr ? K_THR_WR : K_THR_RD;
                    end else if (ctx_off == CTX_OFF_CLAIM) begin
                        if (is_wr) begin
                            // completion: only the id range is checked
                            if (i_write_data >= DATA_W'(SOURCES)) begin
                                o_cmd.status = ST_BAD;
                            end
                        end else begin
                            o_cmd.kind = K_CLAIM;
                        end
                    end else begin
                        o_cmd.status = ST_BAD;
                    end
                end else begin
                    o_cmd.status = ST_UNMAPPED;
                end
            end
            OP_RAISE: begin
                if (i_source >= SRC_W'(SOURCES)) begin
                    o_cmd.status = ST_BAD;
                end else if (i_level) begin
                    o_cmd.kind = K_RAISE;
                    o_cmd.src  = i_source[SRC_IDX_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hdl/icr_queue.sv -----
module icr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  icr_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output icr_pkg::t_cmd  o_cmd
);
    import icr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/icr_back.sv -----
module icr_back #(
    parameter int SOURCES  = 32,
    parameter int CONTEXTS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  icr_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [icr_pkg::DATA_W-1:0]    o_read_data,
    output logic                          o_irq_out,
    output logic [icr_pkg::STATUS_W-1:0]  o_status
);
    import icr_pkg::*;

    localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int CW = $clog2(CONTEXTS);

    logic [DATA_W-1:0]  r_prio   [SOURCES];
    logic [DATA_W-1:0]  r_enable [CONTEXTS];
    logic [DATA_W-1:0]  r_thresh [CONTEXTS];
    logic [SOURCES-1:0] r_pending;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_read_data;
    logic               r_irq;
    t_status            r_status;

    logic [SW-1:0]      sidx;
    logic [CW-1:0]      cidx;
    logic [SOURCES-1:0] ready;
    logic [SW-1:0]      claim_idx;
    logic [SOURCES-1:0] n_pending;
    logic [DATA_W-1:0]  n_enable1;
    logic [DATA_W-1:0]  n_read_data;
    logic               n_irq;

    assign sidx  = i_cmd.src[SW-1:0];
    assign cidx  = i_cmd.ctx[CW-1:0];
    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    // lowest-numbered pending source enabled for the addressed context
    assign ready = r_enable[cidx][SOURCES-1:0] & r_pending;
    always_comb begin
        claim_idx = '0;
        for (int i = SOURCES - 1; i >= 0; i--) begin
            if (ready[i]) begin
                claim_idx = SW'(i);
            end
        end
    end

    // read data and pending update for the current command
    always_comb begin
        n_pending   = r_pending;
        n_read_data = '0;
        case (i_cmd.kind)
            K_PRIO_RD: n_read_data = r_prio[sidx];
            K_PEND_RD: n_read_data = DATA_W'(r_pending);
            K_ENAB_RD: n_read_data = r_enable[cidx];
            K_THR_RD:  n_read_data = r_thresh[cidx];
            K_CLAIM: begin
                if (|ready) begin
                    n_read_data            = DATA_W'(claim_idx);
                    n_pending[claim_idx]   = 1'b0;
                end
            end
            K_RAISE:   n_pending[sidx] = 1'b1;
            default: begin
            end
        endcase
    end

    // interrupt line sees the state left by this command
    assign n_enable1 = (i_cmd.kind == K_ENAB_WR && cidx == CW'(1)) ? i_cmd.data
                                                                    : r_enable[1];
    assign n_irq     = |(n_enable1[SOURCES-1:0] & n_pending);

    // register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SOURCES; i++) begin
                r_prio[i] <= '0;
            end
            for (int c = 0; c < CONTEXTS; c++) begin
                r_enable[c] <= '0;
                r_thresh[c] <= '0;
            end
            r_pending <= '0;
        end else if (o_pop) begin
            r_pending <= n_pending;
            case (i_cmd.kind)
                K_PRIO_WR: r_prio[sidx]   <= i_cmd.data;
                K_ENAB_WR: r_enable[cidx] <= i_cmd.data;
                K_THR_WR:  r_thresh[cidx] <= i_cmd.data;
                default: begin
                end
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_read_data <= n_read_data;
            r_irq       <= n_irq;
            r_status    <= i_cmd.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_irq_out   = r_irq;
    assign o_status    = STATUS_W'(r_status);

endmodule

// ----- hdl/interrupt_controller_regs_top.sv -----
// Simplified platform interrupt controller register block. Each input transfer is a
// bus read, a bus write or a source raise, and each gives exactly one result transfer
// carrying read data, the supervisor interrupt line after the item, and a status code.
// The front decodes the address into a command and a two-entry queue holds it until
// the back applies it to the priority, pending, enable and threshold registers; a claim
// read is a combinational find-first over the enabled pending bits. One item is taken
// per clock when the result side does not stall; an accepted item is written into the
// queue and later, when the result register can load, into that register, which drives
// the result transfer, and up to two items can wait in the queue behind a stalled result.
module interrupt_controller_regs_top #(
    parameter int SOURCES  = 32,
    parameter int CONTEXTS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [icr_pkg::OP_W-1:0]      i_operation,
    input  logic [icr_pkg::ADDR_W-1:0]    i_address,
    input  logic [icr_pkg::DATA_W-1:0]    i_write_data,
    input  logic [icr_pkg::SRC_W-1:0]     i_source,
    input  logic                          i_level,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [icr_pkg::DATA_W-1:0]    o_read_data,
    output logic                          o_irq_out,
    output logic [icr_pkg::STATUS_W-1:0]  o_status
);
    import icr_pkg::*;

    logic full;
    logic push;
    logic pop;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // decode and classify
    icr_front #(
        .SOURCES  (SOURCES),
        .CONTEXTS (CONTEXTS)
    ) u_front (
        .i_valid      (i_in_valid),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_source     (i_source),
        .i_level      (i_level),
        .i_full       (full),
        .o_stall      (o_in_stall),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    // command queue
    icr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // register file, claim logic and result register
    icr_back #(
        .SOURCES  (SOURCES),
        .CONTEXTS (CONTEXTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_data (o_read_data),
        .o_irq_out   (o_irq_out),
        .o_status    (o_status)
    );

endmodule
